@@ sv/dq_pkg.sv @@
package dq_pkg;

    // Default ring depth in words
    localparam int unsigned DEPTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } dq_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } dq_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } dq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       upd;        // apply op: storage access, pointer and count update
        dq_cmd_t    op;
        logic       res_now;    // load output register with an immediate result
        dq_status_t res_status;
        logic       res_pop;    // load output register with the read word
    } dq_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic out_busy;         // output register holds a result not taken this cycle
    } dq_stat_t;

endpackage

@@ sv/dq_ctrl.sv @@
module dq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_cmd,
    input  dq_pkg::dq_stat_t  stat,
    output dq_pkg::dq_ctl_t   ctl
);
    import dq_pkg::*;

    dq_state_t state_reg;
    dq_state_t state_next;
    dq_cmd_t   op;
    logic      accept;
    logic      is_push;

    assign op      = dq_cmd_t'(s_cmd);
    assign is_push = (op == CMD_PUSH_BACK) || (op == CMD_PUSH_FRONT);
    assign s_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign accept  = s_valid && s_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: an accepted pop that succeeds waits in S_READ for the registered read data
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !is_push && !stat.empty) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        ctl            = '0;
        ctl.op         = op;
        ctl.res_status = STAT_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        ctl.res_now    = 1'b1;
                        ctl.upd        = !stat.full;
                        ctl.res_status = stat.full ? STAT_FULL : STAT_OK;
                    end else if (stat.empty) begin
                        ctl.res_now    = 1'b1;
                        ctl.res_status = STAT_EMPTY;
                    end else begin
                        ctl.upd        = 1'b1;
                    end
                end
            end
            S_READ: begin
                ctl.res_pop = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/dq_datapath.sv @@
module dq_datapath #(
    parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dq_pkg::dq_ctl_t     ctl,
    output dq_pkg::dq_stat_t    stat,
    input  logic signed [31:0]  s_push_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_pop_value,
    output logic [1:0]          m_status,
    output logic [4:0]          m_count_after
);
    import dq_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic             wr_en, rd_en;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_value_reg;
    dq_status_t        out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Ring neighbors with explicit wrap
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_W'(DEPTH - 1) : tail_reg - 1'b1;

    // Pointer and count update, storage addresses
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_addr    = head_reg;
        if (ctl.upd) begin
            unique case (ctl.op)
                CMD_PUSH_BACK: begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
                CMD_PUSH_FRONT: begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
                CMD_POP_FRONT: begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                CMD_POP_BACK: begin
                    rd_en      = 1'b1;
                    rd_addr    = tail_dec;
                    tail_next  = tail_dec;
                    count_next = count_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_push_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Count reported in 5 bits
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    // Output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.res_now || ctl.res_pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (ctl.res_now) begin
            out_value_reg  <= '0;
            out_status_reg <= ctl.res_status;
            out_count_reg  <= count_ext[COUNT_W-1:0];
        end else if (ctl.res_pop) begin
            out_value_reg  <= rd_data_reg;
            out_status_reg <= STAT_OK;
            out_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.out_busy = out_valid_reg && !m_ready;

    assign m_valid       = out_valid_reg;
    assign m_pop_value   = out_value_reg;
    assign m_status      = out_status_reg;
    assign m_count_after = out_count_reg;

endmodule

@@ sv/double_ended_queue_core.sv @@
// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_cmd[1:0], s_push_value[31:0]
// m_        m_valid / m_ready   m_pop_value[31:0], m_status[1:0], m_count_after[4:0]
//
// A push or a rejected request loads the output register directly; a successful pop
// passes through the registered read port of the storage memory and the S_READ state.
// Reset clears the pointers, the fill count and the output valid; storage is
// not cleared and holds no valid bits.
// A new request is taken while no pop read is pending and the output register is empty or being drained.
module double_ended_queue_core #(
    parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pop_value,
    output logic [1:0]         m_status,
    output logic [4:0]         m_count_after
);
    import dq_pkg::*;

    dq_ctl_t  ctl;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .stat    (stat),
        .ctl     (ctl)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_count_after (m_count_after)
    );

endmodule

@@ tb/sv/testbench.sv @@
import dq_pkg::*;

// One expected response of the deque
typedef struct {
    logic [WORD_W-1:0]  pop_value;
    dq_status_t         status;
    logic [COUNT_W-1:0] count_after;
} dq_result_t;

// Shadow copy of the deque: predicts each response and checks the DUT against it
class deque_tracker;
    logic [WORD_W-1:0] ring [DEPTH_DEF];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       fill;
    dq_result_t        pending_results [$];
    int                errors;
    int                requests;
    int                results;
    int                full_refusals;
    int                empty_refusals;

    function int unsigned slot_after(int unsigned p);
        return (p == DEPTH_DEF - 1) ? 0 : p + 1;
    endfunction

    function int unsigned slot_before(int unsigned p);
        return (p == 0) ? DEPTH_DEF - 1 : p - 1;
    endfunction

    // Apply one accepted request to the shadow deque, queue its response
    function void note_request(dq_cmd_t cmd, logic [WORD_W-1:0] word);
        dq_result_t r;
        r.pop_value = '0;
        r.status    = STAT_OK;
        requests++;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (fill >= DEPTH_DEF) begin
                    r.status = STAT_FULL;
                    full_refusals++;
                end else if (cmd == CMD_PUSH_BACK) begin
                    ring[tail] = word;
                    tail = slot_after(tail);
                    fill++;
                end else begin
                    // front push: step head back first, then write
                    head = slot_before(head);
                    ring[head] = word;
                    fill++;
                end
            end
            default: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                    empty_refusals++;
                end else if (cmd == CMD_POP_FRONT) begin
                    r.pop_value = ring[head];
                    head = slot_after(head);
                    fill--;
                end else begin
                    // back pop: step tail back first, then read
                    tail = slot_before(tail);
                    r.pop_value = ring[tail];
                    fill--;
                end
            end
        endcase
        r.count_after = COUNT_W'(fill);
        pending_results.push_back(r);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_result(logic [WORD_W-1:0] pop_value, logic [STAT_W-1:0] status,
                               logic [COUNT_W-1:0] count_after);
        dq_result_t r;
        results++;
        if (pending_results.size() == 0) begin
            $error("response with no request outstanding: pop_value %08h status %0d count %0d",
                   pop_value, status, count_after);
            errors++;
            return;
        end
        r = pending_results.pop_front();
        if (pop_value !== r.pop_value) begin
            $error("pop_value mismatch: expected %08h, actual %08h", r.pop_value, pop_value);
            errors++;
        end
        if (status !== r.status) begin
            $error("status mismatch: expected %0d, actual %0d", r.status, status);
            errors++;
        end
        if (count_after !== r.count_after) begin
            $error("count_after mismatch: expected %0d, actual %0d", r.count_after, count_after);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = '0;
    logic signed [31:0] s_push_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pop_value;
    logic [1:0]         m_status;
    logic [4:0]         m_count_after;

    int                 src_idle_pct = 0;
    int                 sink_stall_pct = 0;
    deque_tracker       tracker;

    double_ended_queue_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_count_after (m_count_after)
    );

    // 20-unit clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Response monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result(m_pop_value, m_status, m_count_after);
    end

    // Word source, weighted toward the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Issue one request, with random idle cycles ahead of it
    task automatic send_request(input dq_cmd_t cmd, input logic [31:0] word);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_push_value <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(cmd, word);
    endtask

    // Hold the sender off until every outstanding response is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int      src_pct [4]  = '{0, 52, 0, 13};
        int      sink_pct [4] = '{0, 0, 52, 13};
        int      push_bias [5] = '{90, 50, 15, 70, 30};
        dq_cmd_t cmd;
        tracker = new;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pops, extreme words at both ends, then fill and overfill
        send_request(CMD_POP_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_POP_BACK, 32'h0000_0000);
        send_request(CMD_PUSH_BACK, 32'h8000_0000);
        send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(CMD_POP_BACK, 32'h1234_5678);
        send_request(CMD_POP_FRONT, 32'h0000_0000);
        for (int i = 0; i < DEPTH_DEF; i++)
            send_request((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_word());
        send_request(CMD_PUSH_BACK, 32'hA5A5_A5A5);
        send_request(CMD_PUSH_FRONT, 32'h5A5A_5A5A);
        wait_drained();

        // Random: four idling phases, each swinging the fill level between full and empty
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            for (int chunk = 0; chunk < 5; chunk++) begin
                for (int n = 0; n < 20; n++) begin
                    if ($urandom_range(0, 99) < push_bias[chunk])
                        cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                    else
                        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
                    send_request(cmd, pick_word());
                end
            end
            wait_drained();
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("ran %0d requests through all four end operations, %0d responses checked;",
                 tracker.requests, tracker.results);
        $display("%0d pushes refused on a full deque, %0d pops refused on an empty one",
                 tracker.full_refusals, tracker.empty_refusals);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("double_ended_queue_core regression: pass");
        else
            $display("double_ended_queue_core regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("double_ended_queue_core regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue_core.sv
tb/sv/testbench.sv
